>>> src/linked_ring_node_table_defines.svh
// Assertion macros for the RTL.
`ifndef LINKED_RING_NODE_TABLE_DEFINES_SVH
`define LINKED_RING_NODE_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LRNT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// Next-cycle implication, sampled on clk_i, off during reset.
`define LRNT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

>>> src/lrnt_pkg.sv
`default_nettype none

package lrnt_pkg;

  localparam int NODE_W          = 8;
  localparam int CMD_W           = 3;
  localparam int NODE_COUNT_DFLT = 256;
  localparam int PC_W            = 5;

  localparam logic [CMD_W-1:0] CMD_INIT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CHAIN  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

  // microprogram entry points and jump targets
  localparam logic [PC_W-1:0] PC_FIN_RD  = 5'd0;
  localparam logic [PC_W-1:0] PC_FIN_OUT = 5'd1;
  localparam logic [PC_W-1:0] PC_INIT    = 5'd2;
  localparam logic [PC_W-1:0] PC_CHAIN   = 5'd3;
  localparam logic [PC_W-1:0] PC_SWAP    = 5'd7;
  localparam logic [PC_W-1:0] PC_ADJ     = 5'd17;

  typedef enum logic [1:0] {RD_NONE, RD_A, RD_B, RD_A0} rd_sel_e;
  typedef enum logic [1:0] {LD_NONE, LD_A, LD_B} ld_sel_e;
  typedef enum logic [3:0] {
    WR_NONE, WR_SELF, WR_CH1, WR_CH2,
    WR_SW1, WR_SW2, WR_SW3, WR_SW4,
    WR_ADJ1, WR_ADJ2, WR_ADJ3
  } wr_op_e;
  typedef enum logic [2:0] {CND_NEXT, CND_JMP, CND_SKIP, CND_ADJ, CND_BSINGLE} cond_e;

  typedef struct packed {
    rd_sel_e         rd;
    ld_sel_e         ld;
    wr_op_e          wr;
    logic            xchg;
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            emit;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    rd: RD_NONE, ld: LD_NONE, wr: WR_NONE, xchg: 1'b0,
    cond: CND_NEXT, target: PC_FIN_RD, emit: 1'b0
  };

  typedef struct packed {
    logic skip;
    logic adj;
    logic bsingle;
  } flags_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              nx_en;
    logic [NODE_W-1:0] nx_addr;
    logic [NODE_W-1:0] nx_data;
    logic              pv_en;
    logic [NODE_W-1:0] pv_addr;
    logic [NODE_W-1:0] pv_data;
  } wr_req_t;

endpackage

`default_nettype wire

>>> src/lrnt_seq.sv
`default_nettype none

module lrnt_seq (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [lrnt_pkg::PC_W-1:0]  entry_i,
  input  wire lrnt_pkg::flags_t           flags_i,
  output lrnt_pkg::ctrl_t                 ctrl_o,
  output logic                            run_o
);
  import lrnt_pkg::*;

  function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (pc)
      5'd0:  w.rd = RD_A0;
      5'd1:  w.emit = 1'b1;
      5'd2:  begin w.wr = WR_SELF; w.cond = CND_JMP; end
      5'd3:  w.rd = RD_A;
      5'd4:  begin w.rd = RD_B; w.ld = LD_A; end
      5'd5:  begin w.ld = LD_B; w.wr = WR_CH1; end
      5'd6:  begin w.wr = WR_CH2; w.cond = CND_JMP; end
      5'd7:  w.rd = RD_A;
      5'd8:  begin w.rd = RD_B; w.ld = LD_A; end
      5'd9:  w.ld = LD_B;
      5'd10: w.cond = CND_SKIP;
      5'd11: w.xchg = 1'b1;
      5'd12: begin w.cond = CND_ADJ; w.target = PC_ADJ; end
      5'd13: w.wr = WR_SW1;
      5'd14: w.wr = WR_SW2;
      5'd15: begin w.wr = WR_SW3; w.cond = CND_BSINGLE; end
      5'd16: begin w.wr = WR_SW4; w.cond = CND_JMP; end
      5'd17: w.wr = WR_ADJ1;
      5'd18: w.wr = WR_ADJ2;
      5'd19: begin w.wr = WR_ADJ3; w.cond = CND_JMP; end
      default: w.cond = CND_JMP;
    endcase
    return w;
  endfunction

  logic            run_q, run_d;
  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           word;
  logic            taken;

  always_comb begin
    word = rom_word(pc_q);
    case (word.cond)
      CND_JMP:     taken = 1'b1;
      CND_SKIP:    taken = flags_i.skip;
      CND_ADJ:     taken = flags_i.adj;
      CND_BSINGLE: taken = flags_i.bsingle;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    run_d = run_q;
    pc_d  = pc_q;
    if (!run_q) begin
      if (start_i) begin
        run_d = 1'b1;
        pc_d  = entry_i;
      end
    end else begin
      pc_d = taken ? word.target : pc_q + PC_W'(1);
      if (word.emit) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      pc_q  <= PC_FIN_RD;
    end else begin
      run_q <= run_d;
      pc_q  <= pc_d;
    end
  end

  assign ctrl_o = run_q ? word : CTRL_NOP;
  assign run_o  = run_q;

endmodule

`default_nettype wire

>>> src/lrnt_link_mem.sv
`default_nettype none

module lrnt_link_mem #(
  parameter int Depth = lrnt_pkg::NODE_COUNT_DFLT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lrnt_pkg::rd_req_t            rd_i,
  input  wire lrnt_pkg::wr_req_t            wr_i,
  output logic [lrnt_pkg::NODE_W-1:0]       rd_next_o,
  output logic [lrnt_pkg::NODE_W-1:0]       rd_prev_o,
  output logic                              clr_o
);
  import lrnt_pkg::*;

  localparam int IDX_W = $clog2(Depth);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(Depth - 1);

  logic [NODE_W-1:0] next_mem [Depth];
  logic [NODE_W-1:0] prev_mem [Depth];
  logic [NODE_W-1:0] rd_next_q, rd_prev_q;
  logic              clr_q, clr_d;
  logic [IDX_W-1:0]  clr_idx_q, clr_idx_d;
  logic [IDX_W-1:0]  ridx, nx_widx, pv_widx;
  logic              nx_we, pv_we;
  logic [NODE_W-1:0] nx_wdata, pv_wdata;

  assign ridx = rd_i.addr[IDX_W-1:0];

  // after reset every entry is loaded with its own index, one per cycle
  always_comb begin
    if (clr_q) begin
      nx_we    = 1'b1;
      pv_we    = 1'b1;
      nx_widx  = clr_idx_q;
      pv_widx  = clr_idx_q;
      nx_wdata = NODE_W'(clr_idx_q);
      pv_wdata = NODE_W'(clr_idx_q);
    end else begin
      nx_we    = wr_i.nx_en;
      pv_we    = wr_i.pv_en;
      nx_widx  = wr_i.nx_addr[IDX_W-1:0];
      pv_widx  = wr_i.pv_addr[IDX_W-1:0];
      nx_wdata = wr_i.nx_data;
      pv_wdata = wr_i.pv_data;
    end
    clr_d     = clr_q && (clr_idx_q != LAST_IDX);
    clr_idx_d = clr_q ? clr_idx_q + IDX_W'(1) : clr_idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      next_mem[nx_widx] <= nx_wdata;
    end
    if (pv_we) begin
      prev_mem[pv_widx] <= pv_wdata;
    end
    if (rd_i.en) begin
      rd_next_q <= next_mem[ridx];
      rd_prev_q <= prev_mem[ridx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  assign rd_next_o = rd_next_q;
  assign rd_prev_o = rd_prev_q;
  assign clr_o     = clr_q;

endmodule

`default_nettype wire

>>> src/linked_ring_node_table.sv
// Node table of next/prev links forming rings; every node starts as a ring of one.
// After reset busy stays high while self links load (link depth capped at 256).
// A request is taken when start is high and busy is low; busy stays high while a
// short microprogram runs, and done_o then pulses for one cycle with node_a's links
// after the command. The receiver cannot stall: done_o must be sampled in its cycle.
// The microprogram's length, set by one read and one write port on each link memory,
// depends on the command: shortest for node_a out of range, then query, unused codes
// and chain or swap with node_b out of range, then init, then chain, remove and swaps
// that change nothing, then a swap of adjacent nodes or with a single node, longest
// for any other swap; done_o is high in the first cycle after busy falls.
`default_nettype none
`include "linked_ring_node_table_defines.svh"

module linked_ring_node_table #(
  parameter int NodeCount = lrnt_pkg::NODE_COUNT_DFLT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [lrnt_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic [lrnt_pkg::NODE_W-1:0]  node_a_i,
  input  wire logic [lrnt_pkg::NODE_W-1:0]  node_b_i,
  output logic                              done_o,
  output logic [lrnt_pkg::NODE_W-1:0]       next_of_a_o,
  output logic [lrnt_pkg::NODE_W-1:0]       prev_of_a_o,
  output logic                              is_member_o
);
  import lrnt_pkg::*;

  localparam int LinkDepth = (NodeCount < (1 << NODE_W)) ? NodeCount : (1 << NODE_W);
  localparam logic [16:0] NC = 17'(NodeCount);

  ctrl_t             ctrl;
  flags_t            flags;
  rd_req_t           rd_req;
  wr_req_t           wr_req;
  logic              run;
  logic              clr;
  logic              accept;
  logic              a_oor, b_oor;
  logic [PC_W-1:0]   entry;
  logic [NODE_W-1:0] rd_next, rd_prev;

  logic [NODE_W-1:0] a_q, b_q, a0_q, na_q, pa_q, nb_q, pb_q;
  logic              oor_q;
  logic              done_q, member_q;
  logic [NODE_W-1:0] next_q, prev_q;

  assign busy   = run || clr;
  assign accept = start && !busy;
  assign a_oor  = {9'd0, node_a_i} >= NC;
  assign b_oor  = {9'd0, node_b_i} >= NC;

  always_comb begin
    if (a_oor) begin
      entry = PC_FIN_OUT;
    end else begin
      unique case (cmd_i)
        CMD_INIT:   entry = PC_INIT;
        CMD_CHAIN:  entry = b_oor ? PC_FIN_RD : PC_CHAIN;
        CMD_REMOVE: entry = PC_CHAIN;
        CMD_SWAP:   entry = b_oor ? PC_FIN_RD : PC_SWAP;
        default:    entry = PC_FIN_RD;
      endcase
    end
  end

  always_comb begin
    flags.skip    = (a_q == b_q) || (na_q == a_q && nb_q == b_q) ||
                    (na_q != a_q && nb_q == a_q && na_q == b_q);
    flags.adj     = (na_q == b_q);
    flags.bsingle = (nb_q == b_q);
  end

  lrnt_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .entry_i (entry),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .run_o   (run)
  );

  always_comb begin
    rd_req.en = (ctrl.rd != RD_NONE);
    case (ctrl.rd)
      RD_B:    rd_req.addr = b_q;
      RD_A0:   rd_req.addr = a0_q;
      default: rd_req.addr = a_q;
    endcase
  end

  always_comb begin
    wr_req = '0;
    unique case (ctrl.wr)
      WR_SELF: begin
        wr_req = '{1'b1, a_q, a_q, 1'b1, a_q, a_q};
      end
      WR_CH1: begin
        wr_req = '{1'b1, b_q, a_q, 1'b1, a_q, b_q};
      end
      WR_CH2: begin
        wr_req = '{1'b1, pa_q, nb_q, 1'b1, nb_q, pa_q};
      end
      WR_SW1: begin
        wr_req = '{1'b1, b_q, na_q, 1'b1, b_q, pa_q};
      end
      WR_SW2: begin
        wr_req = '{1'b1, pa_q, b_q, 1'b1, na_q, b_q};
      end
      WR_SW3: begin
        wr_req = '{1'b1, a_q, flags.bsingle ? a_q : nb_q,
                   1'b1, a_q, flags.bsingle ? a_q : pb_q};
      end
      WR_SW4: begin
        wr_req = '{1'b1, pb_q, a_q, 1'b1, nb_q, a_q};
      end
      WR_ADJ1: begin
        wr_req = '{1'b1, a_q, nb_q, 1'b1, a_q, b_q};
      end
      WR_ADJ2: begin
        wr_req = '{1'b1, b_q, a_q, 1'b1, b_q, pa_q};
      end
      WR_ADJ3: begin
        wr_req = '{1'b1, pa_q, b_q, 1'b1, nb_q, a_q};
      end
      default: wr_req = '0;
    endcase
  end

  lrnt_link_mem #(
    .Depth (LinkDepth)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rd_req),
    .wr_i      (wr_req),
    .rd_next_o (rd_next),
    .rd_prev_o (rd_prev),
    .clr_o     (clr)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q   <= node_a_i;
      a0_q  <= node_a_i;
      b_q   <= (cmd_i == CMD_REMOVE) ? node_a_i : node_b_i;
      oor_q <= a_oor;
    end else if (ctrl.xchg && (na_q == a_q || nb_q == a_q)) begin
      a_q  <= b_q;
      b_q  <= a_q;
      na_q <= nb_q;
      nb_q <= na_q;
      pa_q <= pb_q;
      pb_q <= pa_q;
    end
    if (ctrl.ld == LD_A) begin
      na_q <= rd_next;
      pa_q <= rd_prev;
    end
    if (ctrl.ld == LD_B) begin
      nb_q <= rd_next;
      pb_q <= rd_prev;
    end
    if (ctrl.emit) begin
      next_q   <= oor_q ? a0_q : rd_next;
      prev_q   <= oor_q ? a0_q : rd_prev;
      member_q <= !oor_q && (rd_next != a0_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl.emit;
    end
  end

  assign done_o      = done_q;
  assign next_of_a_o = next_q;
  assign prev_of_a_o = prev_q;
  assign is_member_o = member_q;

  `LRNT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `LRNT_ASSERT_NXT(a_done_single, done_o, !done_o)
  `LRNT_ASSERT_NOW(a_member_link, done_o, is_member_o == (next_of_a_o != a0_q))

endmodule

`default_nettype wire

>>> tb/linked_ring_node_table_tb.sv
`default_nettype none

module linked_ring_node_table_tb;
  import lrnt_pkg::*;

  localparam int NODES = NODE_COUNT_DFLT;

  // codes 5..7 are unassigned and behave as query
  localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

  typedef logic [NODE_W-1:0] node_t;

  typedef struct packed {
    node_t nxt;
    node_t prv;
    logic  member;
  } links_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    node_t            a;
    node_t            b;
    bit               typed;
    node_t            nxt;
    node_t            prv;
    logic             member;
  } step_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [CMD_W-1:0] cmd_i;
  node_t            node_a_i;
  node_t            node_b_i;
  logic             done_o;
  node_t            next_of_a_o;
  node_t            prev_of_a_o;
  logic             is_member_o;

  node_t  next_tbl [NODES];
  node_t  prev_tbl [NODES];
  links_t pending_links [$];
  links_t seen;
  int     errors;
  bit     idling;
  node_t  pool [16];

  step_t directed [25] = '{
    '{CMD_QUERY,     8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   1'b0},
    '{CMD_QUERY,     8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 1'b0},
    '{CMD_CHAIN,     8'd1,   8'd0,   1'b1, 8'd0,   8'd0,   1'b1},
    '{CMD_CHAIN,     8'd2,   8'd1,   1'b1, 8'd0,   8'd1,   1'b1},
    '{CMD_SWAP,      8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   1'b0},
    '{CMD_SWAP,      8'd3,   8'd4,   1'b1, 8'd3,   8'd3,   1'b0},
    '{CMD_CHAIN,     8'd255, 8'd254, 1'b1, 8'd254, 8'd254, 1'b1},
    '{CMD_SWAP,      8'd254, 8'd255, 1'b1, 8'd255, 8'd255, 1'b1},
    '{CMD_SWAP,      8'd5,   8'd1,   1'b0, 8'd0,   8'd0,   1'b0},
    '{CMD_SWAP,      8'd0,   8'd5,   1'b0, 8'd0,   8'd0,   1'b0},
    '{CMD_SWAP,      8'd2,   8'd0,   1'b0, 8'd0,   8'd0,   1'b0},
    '{CMD_CHAIN,     8'd255, 8'd2,   1'b0, 8'd0,   8'd0,   1'b0},
    '{CMD_SWAP,      8'd1,   8'd254, 1'b0, 8'd0,   8'd0,   1'b0},
    '{CMD_SWAP,      8'd0,   8'd255, 1'b0, 8'd0,   8'd0,   1'b0},
    '{CMD_CHAIN,     8'd2,   8'd0,   1'b0, 8'd0,   8'd0,   1'b0},
    '{CMD_CHAIN,     8'd7,   8'd7,   1'b1, 8'd7,   8'd7,   1'b0},
    '{CMD_CHAIN,     8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   1'b0},
    '{CMD_REMOVE,    8'd255, 8'd0,   1'b1, 8'd255, 8'd255, 1'b0},
    '{CMD_REMOVE,    8'd2,   8'd255, 1'b0, 8'd0,   8'd0,   1'b0},
    '{CMD_INIT,      8'd5,   8'd170, 1'b1, 8'd5,   8'd5,   1'b0},
    '{CMD_SPARE_LO,  8'd0,   8'd85,  1'b0, 8'd0,   8'd0,   1'b0},
    '{CMD_SPARE_MID, 8'd255, 8'd0,   1'b0, 8'd0,   8'd0,   1'b0},
    '{CMD_SPARE_HI,  8'd170, 8'd85,  1'b0, 8'd0,   8'd0,   1'b0},
    '{CMD_SWAP,      8'd255, 8'd0,   1'b0, 8'd0,   8'd0,   1'b0},
    '{CMD_QUERY,     8'd128, 8'd127, 1'b1, 8'd128, 8'd128, 1'b0}
  };

  linked_ring_node_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .node_a_i    (node_a_i),
    .node_b_i    (node_b_i),
    .done_o      (done_o),
    .next_of_a_o (next_of_a_o),
    .prev_of_a_o (prev_of_a_o),
    .is_member_o (is_member_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // p becomes the predecessor of n; p == n unlinks p
  function automatic void link_after(node_t p, node_t n);
    node_t pn, np;
    pn = next_tbl[p];
    np = prev_tbl[n];
    prev_tbl[n]  = p;
    next_tbl[p]  = n;
    prev_tbl[pn] = np;
    next_tbl[np] = pn;
  endfunction

  function automatic void swap_places(node_t a, node_t b);
    node_t na, pa, nb, pb, t;
    if (a == b) return;
    na = next_tbl[a];
    nb = next_tbl[b];
    if (na == a) begin
      if (nb == b) return;
      t = a; a = b; b = t;
    end else if (nb == a) begin
      if (na == b) return;
      t = a; a = b; b = t;
    end
    na = next_tbl[a];
    pa = prev_tbl[a];
    nb = next_tbl[b];
    pb = prev_tbl[b];
    if (na == b) begin
      prev_tbl[a]  = b;
      next_tbl[a]  = nb;
      prev_tbl[b]  = pa;
      next_tbl[b]  = a;
      prev_tbl[nb] = a;
      next_tbl[pa] = b;
      return;
    end
    prev_tbl[b]  = pa;
    next_tbl[b]  = na;
    prev_tbl[na] = b;
    next_tbl[pa] = b;
    if (nb == b) begin
      next_tbl[a] = a;
      prev_tbl[a] = a;
      return;
    end
    prev_tbl[a]  = pb;
    next_tbl[a]  = nb;
    prev_tbl[nb] = a;
    next_tbl[pb] = a;
  endfunction

  function automatic links_t apply_cmd(logic [CMD_W-1:0] c, node_t a, node_t b);
    links_t r;
    bit b_ok;
    b_ok = int'(b) < NODES;
    if (int'(a) >= NODES) begin
      r.nxt    = a;
      r.prv    = a;
      r.member = 1'b0;
      return r;
    end
    case (c)
      CMD_INIT: begin
        next_tbl[a] = a;
        prev_tbl[a] = a;
      end
      CMD_CHAIN: if (b_ok) link_after(b, a);
      CMD_REMOVE: link_after(a, a);
      CMD_SWAP: if (b_ok) swap_places(a, b);
      default: ;
    endcase
    r.nxt    = next_tbl[a];
    r.prv    = prev_tbl[a];
    r.member = (next_tbl[a] != a);
    return r;
  endfunction

  task automatic flag_mismatch(string what, int want, int got);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $time);
  endtask

  task automatic issue(logic [CMD_W-1:0] c, node_t a, node_t b, bit typed, links_t want);
    links_t calc;
    if (idling && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start    <= 1'b1;
    cmd_i    <= c;
    node_a_i <= a;
    node_b_i <= b;
    do @(posedge clk_i); while (busy);
    calc = apply_cmd(c, a, b);
    pending_links.push_back(typed ? want : calc);
  endtask

  task automatic drain_requests();
    start <= 1'b0;
    while (pending_links.size() != 0) @(posedge clk_i);
  endtask

  function automatic node_t pick_node();
    if ($urandom_range(0, 4) == 0) return node_t'($urandom_range(0, NODES - 1));
    return pool[$urandom_range(0, 15)];
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CMD_CHAIN;
    if (r < 65) return CMD_SWAP;
    if (r < 75) return CMD_REMOVE;
    if (r < 78) return CMD_INIT;
    if (r < 93) return CMD_QUERY;
    case ($urandom_range(0, 2))
      0: return CMD_SPARE_LO;
      1: return CMD_SPARE_MID;
      default: return CMD_SPARE_HI;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_links.size() == 0) begin
        flag_mismatch("unexpected result, next_of_a", -1, next_of_a_o);
      end else begin
        seen = pending_links.pop_front();
        if (next_of_a_o !== seen.nxt) flag_mismatch("next_of_a", seen.nxt, next_of_a_o);
        if (prev_of_a_o !== seen.prv) flag_mismatch("prev_of_a", seen.prv, prev_of_a_o);
        if (is_member_o !== seen.member)
          flag_mismatch("is_member", seen.member, is_member_o);
      end
    end
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    links_t w;
    errors   = 0;
    idling   = 1'b1;
    rst_ni   = 1'b0;
    start    = 1'b0;
    cmd_i    = CMD_QUERY;
    node_a_i = '0;
    node_b_i = '0;
    for (int i = 0; i < NODES; i++) begin
      next_tbl[i] = node_t'(i);
      prev_tbl[i] = node_t'(i);
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      w.nxt    = directed[i].nxt;
      w.prv    = directed[i].prv;
      w.member = directed[i].member;
      issue(directed[i].cmd, directed[i].a, directed[i].b, directed[i].typed, w);
    end

    w = '0;
    for (int phase = 0; phase < 3; phase++) begin
      idling = (phase != 1);
      for (int n = 0; n < (phase == 1 ? 100 : (phase == 0 ? 200 : 150)); n++) begin
        if (n % 50 == 0) begin
          foreach (pool[k]) pool[k] = node_t'($urandom_range(0, NODES - 1));
          pool[0]  = '0;
          pool[15] = node_t'(NODES - 1);
        end
        issue(pick_cmd(), pick_node(), pick_node(), 1'b0, w);
      end
      if (phase == 0) drain_requests();
    end

    drain_requests();
    repeat (20) @(posedge clk_i);
    if (pending_links.size() != 0) errors++;
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> linked_ring_node_table.f
+incdir+src
src/lrnt_pkg.sv
src/lrnt_seq.sv
src/lrnt_link_mem.sv
src/linked_ring_node_table.sv
tb/linked_ring_node_table_tb.sv
